/* hw/rtl/digital_search_tree_map_unit_macros.svh */
// Assertion macros for the search tree map unit
`ifndef DIGITAL_SEARCH_TREE_MAP_UNIT_MACROS_SVH
`define DIGITAL_SEARCH_TREE_MAP_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DSTM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DSTM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DSTM_ASSERT(label, clk, rst, prop, msg)
`define DSTM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* hw/rtl/dstm_pkg.sv */
package dstm_pkg;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_ABSENT      = 2'd1;
  localparam logic [1:0] ST_OVERWRITTEN = 2'd2;
  localparam logic [1:0] ST_FULL        = 2'd3;

  localparam logic [4:0] SHIFT_RESET = 5'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD,        // issue node read
    S_EVAL,      // examine node data
    S_RED_RD,    // reread reduction node
    S_RED_EVAL,
    S_ALLOC_RD,  // read free-list head link
    S_ALLOC_EVAL,
    S_WR_NEW,    // write new node
    S_WR_LINK,   // patch reduction node, or read parent for patching
    S_RM_RD,     // leftmost walk read
    S_RM_EVAL,
    S_RM_LEAF_RD,
    S_RM_LEAF_EVAL,
    S_RM_CUT,
    S_RM_FILL,
    S_FREE,
    S_DONE
  } state_t;
endpackage

/* hw/rtl/digital_search_tree_map_unit.sv */
// Search tree map unit: one request in flight, single-port node memory.
// Each node visited takes a read state and an evaluate state; insert adds
// allocate/write-back states, remove a leftmost-leaf walk, cut and refill;
// clear, or a lookup or remove on an empty tree, goes straight to done.
// The next request is taken only once the result has been accepted.
// Reset (rst, synchronous): tree empty, free list empty, shift = 2.
module digital_search_tree_map_unit #(
  parameter int NODES = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic [4:0] level_zero_shift_wr_data,
  input  logic level_zero_shift_wr_en,
  input  logic s_tvalid,
  output logic s_tready,
  // tdata: key [31:0], value [63:32]
  input  logic [63:0] s_tdata,
  // tuser: cmd [1:0]
  input  logic [1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // tdata: found_value [31:0]
  output logic [31:0] m_tdata,
  // tuser: status [1:0]
  output logic [1:0] m_tuser
);
  import dstm_pkg::*;
`include "digital_search_tree_map_unit_macros.svh"

  localparam int AW = $clog2(NODES);
  localparam int LW = AW + 1;
  localparam int KW = KEY_BITS;
  localparam int VW = VALUE_BITS;
  localparam logic [LW-1:0] NIL = LW'(NODES);
  localparam int SW = $clog2(NODES + 2) + 1;

  // Node memory, one entry per node, single port
  typedef struct packed {
    logic [KW-1:0] key;
    logic [VW-1:0] val;
    logic [LW-1:0] left;
    logic [LW-1:0] right;
  } node_t;

  node_t mem [NODES];
  logic mem_we;
  logic [AW-1:0] mem_addr;
  node_t mem_wdata;
  node_t rd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd <= mem[mem_addr];
  end

  // Architectural and walk registers
  logic [4:0] shift;
  state_t state, state_next;
  logic [LW-1:0] root, free_head, fresh;
  logic [1:0] cmd;
  logic [KW-1:0] key;
  logic [VW-1:0] value;
  logic [LW-1:0] cur, parent, red, red_m, rm_node, leaf;
  logic dir, leaf_dir;
  logic [6:0] lvl;
  logic [SW-1:0] steps;
  logic [1:0] st;
  logic [31:0] fv;
  logic mvalid;
  node_t red_node;
  // whether the pending write-back uses the reduction node
  logic use_red;

  logic [LW-1:0] root_n, free_n, fresh_n, cur_n, parent_n, red_n, rmn_n, leaf_n;
  logic dir_n, leaf_dir_n, use_red_n, mvalid_n;
  logic [6:0] lvl_n;
  logic [SW-1:0] steps_n;
  logic [1:0] st_n;
  logic [31:0] fv_n;
  node_t red_node_n;
  logic [LW-1:0] red_m_n;

  // Key bit at a level; beyond key width reads as zero
  function automatic logic kbit(input logic [KW-1:0] k, input logic [4:0] sh,
                                input logic [6:0] lv);
    logic [7:0] pos;
    pos = 8'(sh) + 8'(lv);
    if (pos >= 8'(KW)) return 1'b0;
    return k[pos[$clog2(KW)-1:0]];
  endfunction

  logic d, kd, lnil, rnil;
  logic [LW-1:0] child;
  always_comb begin
    d = kbit(key, shift, lvl);
    kd = kbit(rd.key, shift, lvl);
    lnil = rd.left >= NIL;
    rnil = rd.right >= NIL;
    child = d ? rd.right : rd.left;
  end

  assign s_tready = (state == S_IDLE) && !mvalid;
  assign m_tvalid = mvalid;
  assign m_tdata  = fv;
  assign m_tuser  = st;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      shift <= SHIFT_RESET;
      root <= NIL;
      free_head <= NIL;
      fresh <= '0;
      mvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (level_zero_shift_wr_en) shift <= level_zero_shift_wr_data;
      root <= root_n;
      free_head <= free_n;
      fresh <= fresh_n;
      mvalid <= mvalid_n;
    end
  end

  // Walk payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd <= s_tuser;
      key <= s_tdata[KW-1:0];
      value <= s_tdata[32 +: VW];
    end
    cur <= cur_n; parent <= parent_n; red <= red_n; rm_node <= rmn_n;
    leaf <= leaf_n; dir <= dir_n; leaf_dir <= leaf_dir_n; lvl <= lvl_n;
    steps <= steps_n; st <= st_n; fv <= fv_n; red_node <= red_node_n;
    red_m <= red_m_n; use_red <= use_red_n;
  end

  // Sequencer
  always_comb begin
    state_next = state;
    root_n = root; free_n = free_head; fresh_n = fresh;
    cur_n = cur; parent_n = parent; red_n = red; rmn_n = rm_node; leaf_n = leaf;
    dir_n = dir; leaf_dir_n = leaf_dir; lvl_n = lvl; steps_n = steps;
    st_n = st; fv_n = fv; red_node_n = red_node; red_m_n = red_m;
    use_red_n = use_red; mvalid_n = mvalid;
    mem_we = 1'b0; mem_addr = cur[AW-1:0]; mem_wdata = rd;
    if (mvalid && m_tready) mvalid_n = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          st_n = ST_OK; fv_n = '0;
          cur_n = root; parent_n = NIL; red_n = NIL; lvl_n = '0; steps_n = '0;
          dir_n = 1'b0;
          if (s_tuser == CMD_CLEAR) begin
            root_n = NIL; free_n = NIL; fresh_n = '0;
            state_next = S_DONE;
          end else if (root >= NIL) begin
            if (s_tuser == CMD_INSERT) begin
              use_red_n = 1'b0;
              state_next = S_ALLOC_RD;
            end else begin
              st_n = ST_ABSENT;
              state_next = S_DONE;
            end
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_RD: begin
        mem_addr = cur[AW-1:0];
        state_next = S_EVAL;
      end
      S_EVAL: begin
        steps_n = steps + 1'b1;
        if (rd.key == key) begin
          fv_n = 32'(rd.val);
          if (cmd == CMD_INSERT) begin
            st_n = ST_OVERWRITTEN;
            mem_we = 1'b1; mem_addr = cur[AW-1:0];
            mem_wdata = rd; mem_wdata.val = value;
            state_next = S_DONE;
          end else if (cmd == CMD_REMOVE) begin
            rmn_n = cur;
            if (lnil && rnil) begin
              // unlink the leaf and free it
              state_next = S_FREE;
              leaf_n = cur;
              if (parent >= NIL) root_n = NIL;
              else begin
                state_next = S_RM_CUT;
                rmn_n = parent;
              end
              leaf_dir_n = dir;
              cur_n = parent;
            end else begin
              state_next = S_RM_RD;
            end
          end else begin
            state_next = S_DONE;
          end
        end else if (steps > SW'(NODES)) begin
          st_n = (cmd == CMD_INSERT) ? ST_FULL : ST_ABSENT;
          state_next = S_DONE;
        end else if (cmd == CMD_INSERT) begin
          if ((!d && !lnil && rnil && kd) || (d && !rnil && lnil && !kd))
            red_n = cur;
          if (child >= NIL) begin
            parent_n = cur; dir_n = d;
            use_red_n = ((!d && !lnil && rnil && kd) || (d && !rnil && lnil && !kd))
                        || (red < NIL);
            if (((!d && !lnil && rnil && kd) || (d && !rnil && lnil && !kd))) begin
              red_node_n = rd;
              red_m_n = cur;
              state_next = S_ALLOC_RD;
            end else if (red < NIL) begin
              red_m_n = red;
              state_next = S_RED_RD;
            end else state_next = S_ALLOC_RD;
          end else begin
            // hold the level at 7'h7F, the top of its range
            cur_n = child; lvl_n = (lvl == 7'h7F) ? lvl : lvl + 1'b1;
            state_next = S_RD;
          end
        end else begin
          if (child >= NIL) begin
            st_n = ST_ABSENT; state_next = S_DONE;
          end else begin
            parent_n = cur; dir_n = d; cur_n = child;
            lvl_n = (lvl == 7'h7F) ? lvl : lvl + 1'b1;
            state_next = S_RD;
          end
        end
      end
      S_RED_RD: begin
        mem_addr = red_m[AW-1:0];
        state_next = S_RED_EVAL;
      end
      S_RED_EVAL: begin
        red_node_n = rd;
        state_next = S_ALLOC_RD;
      end
      // Pick a node: free-list head (read its link) or a fresh one, else report full
      S_ALLOC_RD: begin
        if (free_head < NIL) begin
          mem_addr = free_head[AW-1:0];
          state_next = S_ALLOC_EVAL;
        end else if (fresh < NIL) begin
          leaf_n = fresh; fresh_n = fresh + 1'b1;
          state_next = S_WR_NEW;
        end else begin
          st_n = ST_FULL; state_next = S_DONE;
        end
      end
      S_ALLOC_EVAL: begin
        leaf_n = free_head; free_n = rd.left;
        state_next = S_WR_NEW;
      end
      S_WR_NEW: begin
        mem_we = 1'b1; mem_addr = leaf[AW-1:0];
        mem_wdata.left = NIL; mem_wdata.right = NIL;
        if (use_red) begin
          mem_wdata.key = red_node.key; mem_wdata.val = red_node.val;
        end else begin
          mem_wdata.key = key; mem_wdata.val = value;
        end
        if (!use_red && parent >= NIL) begin
          root_n = leaf; state_next = S_DONE;
        end else state_next = S_WR_LINK;
      end
      S_WR_LINK: begin
        mem_we = 1'b1;
        if (use_red) begin
          mem_addr = red_m[AW-1:0];
          mem_wdata = red_node; mem_wdata.key = key; mem_wdata.val = value;
          if (red_node.left >= NIL) mem_wdata.left = leaf;
          else mem_wdata.right = leaf;
          state_next = S_DONE;
        end else begin
          // read the parent, patch its link next cycle
          mem_we = 1'b0;
          mem_addr = parent[AW-1:0];
          use_red_n = 1'b0;
          state_next = S_RM_FILL;
          leaf_dir_n = dir;
          rmn_n = parent;
          red_m_n = leaf;
        end
      end
      // Leftmost-leaf walk for remove
      S_RM_RD: begin
        mem_addr = cur[AW-1:0];
        state_next = S_RM_EVAL;
      end
      S_RM_EVAL: begin
        parent_n = cur;
        leaf_dir_n = lnil;
        cur_n = lnil ? rd.right : rd.left;
        red_node_n = rd;
        if ((lnil ? rd.right : rd.left) >= NIL) state_next = S_DONE;
        else state_next = S_RM_LEAF_RD;
      end
      S_RM_LEAF_RD: begin
        mem_addr = cur[AW-1:0];
        state_next = S_RM_LEAF_EVAL;
      end
      S_RM_LEAF_EVAL: begin
        if (lnil && rnil) begin
          // cut the leaf from its parent, then move its data up
          leaf_n = cur;
          red_m_n = cur;
          mem_we = 1'b1; mem_addr = parent[AW-1:0];
          mem_wdata = red_node;
          if (leaf_dir) mem_wdata.right = NIL; else mem_wdata.left = NIL;
          red_node_n = rd;
          state_next = S_RM_FILL;
          use_red_n = 1'b1;
        end else begin
          parent_n = cur; leaf_dir_n = lnil;
          cur_n = lnil ? rd.right : rd.left;
          red_node_n = rd;
          state_next = S_RM_LEAF_RD;
        end
      end
      S_RM_CUT: begin
        mem_addr = cur[AW-1:0];
        state_next = S_RM_FILL;
        use_red_n = 1'b0;
        red_m_n = NIL;
      end
      S_RM_FILL: begin
        if (use_red) begin
          // refill removed node: read it first
          mem_addr = rm_node[AW-1:0];
          use_red_n = 1'b0;
          red_m_n = leaf;
          // next cycle rd holds rm_node
          cur_n = rm_node;
          steps_n = '0;
          state_next = S_FREE;
          red_n = NIL;
          lvl_n = 7'd1;
        end else begin
          // patch link of node now in rd (parent of leaf or new node)
          mem_we = 1'b1; mem_addr = rm_node[AW-1:0];
          mem_wdata = rd;
          if (red_m < NIL) begin
            if (leaf_dir) mem_wdata.right = red_m; else mem_wdata.left = red_m;
            state_next = S_DONE;
          end else begin
            if (leaf_dir) mem_wdata.right = NIL; else mem_wdata.left = NIL;
            state_next = S_FREE;
            lvl_n = '0;
          end
        end
      end
      S_FREE: begin
        if (lvl == 7'd1) begin
          // write moved data into removed node, then free the leaf
          mem_we = 1'b1; mem_addr = rm_node[AW-1:0];
          mem_wdata = rd;
          mem_wdata.key = red_node.key; mem_wdata.val = red_node.val;
          if (rm_node == parent)
            if (leaf_dir) mem_wdata.right = NIL; else mem_wdata.left = NIL;
          lvl_n = '0;
        end else begin
          mem_we = 1'b1; mem_addr = leaf[AW-1:0];
          mem_wdata = rd; mem_wdata.left = free_head;
          free_n = leaf;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        mvalid_n = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `DSTM_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "result dropped")
  `DSTM_ASSERT(a_no_accept_busy, clk, rst, state != S_IDLE |-> !s_tready, "accept while busy")
  `DSTM_ASSERT(a_fresh_range, clk, rst, fresh <= NIL, "fresh count overflow")
  `DSTM_ASSERT(a_done_result, clk, rst, state == S_DONE |=> m_tvalid, "missing result")
endmodule

/* tb/sv/dstm_checker.sv */
module dstm_checker #(
  parameter int NODES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic [1:0]  m_tuser,
  output int          fail_count,
  output int          pending
);
  import dstm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [10:0] NIL = 11'(NODES);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
  } answer_t;

  // Shadow copy of the node memory and tree bookkeeping
  logic [31:0] nkey [NODES];
  logic [31:0] nval [NODES];
  logic [10:0] nleft [NODES];
  logic [10:0] nright [NODES];
  logic [10:0] root;
  logic [10:0] free_head;
  logic [10:0] fresh;
  logic [4:0]  shift;

  answer_t answers_due[$];

  assign pending = answers_due.size();

  function automatic logic branch_bit(logic [31:0] k, int lvl);
    int pos;
    pos = int'(shift) + lvl;
    if (pos >= 32) return 1'b0;
    return k[pos];
  endfunction

  function automatic logic [10:0] grab_node(logic [31:0] k, logic [31:0] v);
    logic [10:0] n;
    if (free_head < NIL) begin
      n = free_head;
      free_head = nleft[n];
    end else if (fresh < NIL) begin
      n = fresh;
      fresh = fresh + 1'b1;
    end else begin
      return NIL;
    end
    nkey[n] = k;
    nval[n] = v;
    nleft[n] = NIL;
    nright[n] = NIL;
    return n;
  endfunction

  function automatic answer_t tree_insert(logic [31:0] k, logic [31:0] v);
    logic [10:0] n, red, parent, m, c;
    logic d, kd, dir;
    int lvl;
    n = root;
    red = NIL;
    parent = NIL;
    dir = 1'b0;
    lvl = 0;
    if (n >= NIL) begin
      m = grab_node(k, v);
      if (m >= NIL) return '{ST_FULL, 32'd0};
      root = m;
      return '{ST_OK, 32'd0};
    end
    for (int steps = 0; steps <= NODES; steps++) begin
      if (nkey[n] == k) begin
        answer_t a;
        a = '{ST_OVERWRITTEN, nval[n]};
        nval[n] = v;
        return a;
      end
      d = branch_bit(k, lvl);
      kd = branch_bit(nkey[n], lvl);
      // one-way node whose own key points to the empty side
      if (!d && nleft[n] < NIL && nright[n] >= NIL && kd) red = n;
      if (d && nright[n] < NIL && nleft[n] >= NIL && !kd) red = n;
      c = d ? nright[n] : nleft[n];
      if (c >= NIL) begin
        parent = n;
        dir = d;
        break;
      end
      n = c;
      lvl++;
    end
    if (red < NIL) begin
      m = grab_node(nkey[red], nval[red]);
      if (m >= NIL) return '{ST_FULL, 32'd0};
      if (nleft[red] >= NIL) nleft[red] = m;
      else nright[red] = m;
      nkey[red] = k;
      nval[red] = v;
      return '{ST_OK, 32'd0};
    end
    if (parent >= NIL) return '{ST_FULL, 32'd0};
    m = grab_node(k, v);
    if (m >= NIL) return '{ST_FULL, 32'd0};
    if (dir) nright[parent] = m;
    else nleft[parent] = m;
    return '{ST_OK, 32'd0};
  endfunction

  // Move the leftmost leaf below n into n and free the leaf
  function automatic void pull_leftmost(logic [10:0] n);
    logic [10:0] cur, c;
    logic go_right;
    cur = n;
    for (int steps = 0; steps <= NODES; steps++) begin
      go_right = nleft[cur] >= NIL;
      c = go_right ? nright[cur] : nleft[cur];
      if (c >= NIL) return;
      if (nleft[c] >= NIL && nright[c] >= NIL) begin
        if (go_right) nright[cur] = NIL;
        else nleft[cur] = NIL;
        nkey[n] = nkey[c];
        nval[n] = nval[c];
        nleft[c] = free_head;
        free_head = c;
        return;
      end
      cur = c;
    end
  endfunction

  function automatic answer_t tree_search(logic [31:0] k, logic remove);
    logic [10:0] n, parent, c;
    logic dir, hit;
    logic [31:0] v;
    int lvl;
    n = root;
    parent = NIL;
    dir = 1'b0;
    hit = 1'b0;
    lvl = 0;
    for (int steps = 0; n < NIL && steps <= NODES; steps++) begin
      if (nkey[n] == k) begin
        hit = 1'b1;
        break;
      end
      dir = branch_bit(k, lvl);
      c = dir ? nright[n] : nleft[n];
      parent = n;
      n = c;
      lvl++;
    end
    if (!hit) return '{ST_ABSENT, 32'd0};
    v = nval[n];
    if (remove) begin
      if (nleft[n] >= NIL && nright[n] >= NIL) begin
        nleft[n] = free_head;
        free_head = n;
        if (parent >= NIL) root = NIL;
        else if (dir) nright[parent] = NIL;
        else nleft[parent] = NIL;
      end else begin
        pull_leftmost(n);
      end
    end
    return '{ST_OK, v};
  endfunction

  // Predict on each accepted request, compare on each accepted answer
  always @(posedge clk) begin
    if (rst) begin
      root = NIL;
      free_head = NIL;
      fresh = '0;
      shift = SHIFT_RESET;
      answers_due.delete();
      fail_count <= 0;
    end else begin
      answer_t exp_a;
      if (cfg_wr_en) shift = cfg_wr_data;
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          CMD_INSERT: exp_a = tree_insert(s_tdata[31:0], s_tdata[63:32]);
          CMD_CLEAR: begin
            root = NIL;
            free_head = NIL;
            fresh = '0;
            exp_a = '{ST_OK, 32'd0};
          end
          CMD_REMOVE: exp_a = tree_search(s_tdata[31:0], 1'b1);
          default: exp_a = tree_search(s_tdata[31:0], 1'b0);
        endcase
        answers_due.push_back(exp_a);
      end
      if (m_tvalid && m_tready) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected answer status=%0d value=%h", $time, m_tuser, m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_a = answers_due.pop_front();
          if (m_tuser !== exp_a.status || m_tdata !== exp_a.value) begin
            $display("%0t: mismatch expected status=%0d value=%h actual status=%0d value=%h",
                     $time, exp_a.status, exp_a.value, m_tuser, m_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* tb/sv/tb_digital_search_tree_map_unit.sv */
module tb_digital_search_tree_map_unit;
  import dstm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [4:0]  shift_wr_data = '0;
  logic        shift_wr_en = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  int          fail_count;
  int          pending;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_go = 1'b0;
  logic [4:0]  cur_shift = SHIFT_RESET;
  logic [31:0] key_pool [16];

  always #1 clk = ~clk;

  digital_search_tree_map_unit u_dut (
    .clk(clk), .rst(rst),
    .level_zero_shift_wr_data(shift_wr_data),
    .level_zero_shift_wr_en(shift_wr_en),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  dstm_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_wr_en(shift_wr_en), .cfg_wr_data(shift_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else begin
        m_tready = $urandom_range(99) >= recv_stall_pct;
      end
    end
  end

  task automatic send(logic [1:0] cmd, logic [31:0] key, logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = cmd;
    s_tdata = {value, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain outstanding answers, then let the block settle
  task automatic drain();
    s_tvalid = 1'b0;
    wait (pending == 0);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_shift(logic [4:0] v);
    drain();
    shift_wr_en = 1'b1;
    shift_wr_data = v;
    cur_shift = v;
    @(negedge clk);
    shift_wr_en = 1'b0;
  endtask

  function automatic logic [31:0] aligned_key();
    logic [31:0] k;
    k = $urandom;
    // mostly keep the ignored low bits clear
    if ($urandom_range(99) < 85) k = k & ~((32'd1 << cur_shift) - 1);
    return k;
  endfunction

  task automatic mixed_phase(int count, int idle, int stall);
    logic [1:0] cmd;
    logic [31:0] k;
    int r;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    foreach (key_pool[i]) key_pool[i] = aligned_key();
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 42) cmd = CMD_INSERT;
      else if (r < 68) cmd = CMD_LOOKUP;
      else if (r < 97) cmd = CMD_REMOVE;
      else cmd = CMD_CLEAR;
      k = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(15)];
      send(cmd, k, $urandom);
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Directed: empty tree, extremes, overwrite, reduction, removes, clear
    send(CMD_LOOKUP, 32'h0, 32'h0);
    send(CMD_REMOVE, 32'hFFFF_FFFC, 32'h0);
    send(CMD_INSERT, 32'h0, 32'h0);
    send(CMD_INSERT, 32'hFFFF_FFFC, 32'hFFFF_FFFF);
    send(CMD_INSERT, 32'hFFFF_FFFC, 32'h1234_5678);
    send(CMD_LOOKUP, 32'hFFFF_FFFC, 32'h0);
    send(CMD_INSERT, 32'h0000_0008, 32'h8);
    send(CMD_INSERT, 32'h0000_0004, 32'h4);
    send(CMD_INSERT, 32'h0000_0010, 32'h10);
    send(CMD_INSERT, 32'h0000_0018, 32'h18);
    send(CMD_INSERT, 32'h0000_0003, 32'h3);
    send(CMD_LOOKUP, 32'h0000_0003, 32'h0);
    send(CMD_LOOKUP, 32'h0000_0000, 32'h0);
    send(CMD_REMOVE, 32'h0000_0000, 32'h0);
    send(CMD_LOOKUP, 32'h0000_0000, 32'h0);
    send(CMD_REMOVE, 32'h0000_0018, 32'h0);
    send(CMD_INSERT, 32'h0000_0020, 32'hA5A5_A5A5);
    send(CMD_LOOKUP, 32'h0000_0010, 32'h0);
    send(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(CMD_LOOKUP, 32'hFFFF_FFFC, 32'h0);

    // Random mix over several shift settings and idling patterns
    mixed_phase(60, 0, 0);
    write_shift(5'd0);
    mixed_phase(60, 55, 0);
    write_shift(5'd31);
    mixed_phase(60, 0, 55);
    write_shift(5'd2);
    hold_go = 1'b1;
    mixed_phase(60, 0, 20);
    write_shift(5'($urandom_range(31)));
    mixed_phase(60, 20, 20);

    // Fill the pool past its size to reach the full status
    write_shift(5'd0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send(CMD_CLEAR, 32'h0, 32'h0);
    for (int i = 0; i < 1040; i++) send(CMD_INSERT, $urandom, $urandom);
    mixed_phase(40, 20, 20);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("tb_digital_search_tree_map_unit: done, clean");
    end else begin
      $display("tb_digital_search_tree_map_unit: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("tb_digital_search_tree_map_unit: done, errors");
    $finish;
  end
endmodule
